FILE: design/mcm_pkg.sv
// Shared widths, register codes and interface structs for the channel mixer.
package mcm_pkg;

	localparam int ROWS       = 16;
	localparam int COLS       = 16;
	localparam int OUTS       = 16;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLS);
	localparam int STEP_W     = $clog2(OUTS);
	localparam int CNT_W      = $clog2(OUTS + 1);
	localparam int COEF_W     = 18;
	localparam int SAMP_W     = 16;
	localparam int ACC_W      = 40;
	localparam int PROD_W     = SAMP_W + COEF_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int BANK_DEPTH = ROWS * COLS / 2;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd2;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// One coefficient fetch issued to the store and the multiplier pipeline.
	typedef struct packed {
		logic              valid;
		logic              live;
		logic              cplx;
		logic [STEP_W-1:0] step;
	} mac_req_t;

	// One product term on its way into the accumulator ring.
	typedef struct packed {
		logic                    valid;
		logic                    live;
		logic signed [SUM_W-1:0] re;
		logic signed [SUM_W-1:0] im;
	} contrib_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
	} acc_t;

endpackage

FILE: design/mcm_coef_store.sv
// Coefficient memory split into even and odd column banks, with per-entry valid bits.
module mcm_coef_store import mcm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [ROW_W-1:0]         wr_row,
	input  logic [COL_W-1:0]         wr_col,
	input  logic signed [COEF_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [BANK_AW-1:0]       rd_addr,
	output logic signed [COEF_W-1:0] rd_even,
	output logic signed [COEF_W-1:0] rd_odd
);

	logic [COEF_W-1:0]     even_mem [BANK_DEPTH];
	logic [COEF_W-1:0]     odd_mem  [BANK_DEPTH];
	logic [BANK_DEPTH-1:0] even_vld_q;
	logic [BANK_DEPTH-1:0] odd_vld_q;
	logic [COEF_W-1:0]     even_rd_q;
	logic [COEF_W-1:0]     odd_rd_q;
	logic                  even_hit_q;
	logic                  odd_hit_q;
	logic [BANK_AW-1:0]    wr_addr;

	assign wr_addr = {wr_row, wr_col[COL_W-1:1]};

	always_ff @(posedge clk) begin
		if (wr_en && !wr_col[0]) begin
			even_mem[wr_addr] <= wr_data;
		end
		if (wr_en && wr_col[0]) begin
			odd_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			even_rd_q <= even_mem[rd_addr];
			odd_rd_q  <= odd_mem[rd_addr];
		end
	end

	// An entry never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_vld_q <= '0;
			odd_vld_q  <= '0;
			even_hit_q <= 1'b0;
			odd_hit_q  <= 1'b0;
		end else begin
			if (wr_en && !wr_col[0]) begin
				even_vld_q[wr_addr] <= 1'b1;
			end
			if (wr_en && wr_col[0]) begin
				odd_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				even_hit_q <= even_vld_q[rd_addr];
				odd_hit_q  <= odd_vld_q[rd_addr];
			end
		end
	end

	assign rd_even = even_hit_q ? signed'(even_rd_q) : '0;
	assign rd_odd  = odd_hit_q ? signed'(odd_rd_q) : '0;

endmodule

FILE: design/mcm_mac.sv
// Multiply pipeline: coefficient select, four products, then the complex combine.
module mcm_mac import mcm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mac_req_t                 req,
	input  logic signed [SAMP_W-1:0] sample_re,
	input  logic signed [SAMP_W-1:0] sample_im,
	input  logic signed [COEF_W-1:0] coef_even,
	input  logic signed [COEF_W-1:0] coef_odd,
	output contrib_t                 contrib,
	output logic                     busy
);

	mac_req_t                 req_s1;
	logic                     valid_s2;
	logic                     live_s2;
	logic                     cplx_s2;
	logic signed [PROD_W-1:0] p_rr_s2;
	logic signed [PROD_W-1:0] p_ii_s2;
	logic signed [PROD_W-1:0] p_ri_s2;
	logic signed [PROD_W-1:0] p_ir_s2;
	logic                     valid_s3;
	logic                     live_s3;
	logic signed [SUM_W-1:0]  re_s3;
	logic signed [SUM_W-1:0]  im_s3;
	logic signed [COEF_W-1:0] cr;
	logic signed [COEF_W-1:0] ci;

	// In real mode the column parity picks the bank; in complex mode the pair
	// is the real part in the even bank and the imaginary part in the odd bank.
	always_comb begin
		ci = coef_odd;
		if (req_s1.cplx) begin
			cr = coef_even;
		end else begin
			cr = req_s1.step[0] ? coef_odd : coef_even;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1   <= '0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			req_s1   <= req;
			valid_s2 <= req_s1.valid;
			valid_s3 <= valid_s2;
		end
	end

	// The imaginary sum only collects products of complex-mode samples.
	always_ff @(posedge clk) begin
		live_s2 <= req_s1.live;
		cplx_s2 <= req_s1.cplx;
		p_rr_s2 <= PROD_W'(sample_re * cr);
		p_ii_s2 <= PROD_W'(sample_im * ci);
		p_ri_s2 <= PROD_W'(sample_re * ci);
		p_ir_s2 <= PROD_W'(sample_im * cr);
		live_s3 <= live_s2;
		if (cplx_s2) begin
			re_s3 <= SUM_W'(p_rr_s2) - SUM_W'(p_ii_s2);
			im_s3 <= SUM_W'(p_ri_s2) + SUM_W'(p_ir_s2);
		end else begin
			re_s3 <= SUM_W'(p_rr_s2);
			im_s3 <= '0;
		end
	end

	assign contrib = '{valid: valid_s3, live: live_s3, re: re_s3, im: im_s3};
	assign busy    = req_s1.valid | valid_s2 | valid_s3;

endmodule

FILE: design/mcm_acc_cell.sv
// One accumulator cell of the rotating ring; it takes its neighbor's sums on each shift.
module mcm_acc_cell import mcm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     shift,
	input  acc_t     prev,
	input  contrib_t add,
	output acc_t     acc
);

	acc_t acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (shift) begin
			acc_q.re <= prev.re + (add.live ? ACC_W'(add.re) : '0);
			acc_q.im <= prev.im + (add.live ? ACC_W'(add.im) : '0);
		end
	end

	assign acc = acc_q;

endmodule

FILE: design/matrix_channel_mixer.sv
// Top level of the channel mixing matrix: control sequencer, coefficient store and ring.
//
// A coefficient load request is written straight into the store. A sample request holds off
// the next request while the sequencer fetches one coefficient pair per cycle for all 16 ring
// positions and the three-stage multiply pipeline then drains into the accumulator ring,
// which rotates by one cell per product. The sample that closes a frame adds a phase in which
// the ring rotates once past the output register, handing out one result per used output
// channel and clearing itself; a stalled output stretches this phase. The store needs no
// clearing pass after reset: per-entry valid bits make unwritten coefficients zero.
module matrix_channel_mixer import mcm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        cmd,
	input  logic [ROW_W-1:0]            coef_row,
	input  logic [COL_W-1:0]            coef_column,
	input  logic signed [COEF_W-1:0]    coef_value,
	input  logic signed [SAMP_W-1:0]    sample_real,
	input  logic signed [SAMP_W-1:0]    sample_imag,
	input  logic                        gap,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [STEP_W-1:0]           out_channel,
	output logic signed [ACC_W-1:0]     out_real,
	output logic signed [ACC_W-1:0]     out_imag,
	output logic                        frame_last
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(OUTS - 1);
	localparam logic [CNT_W-1:0]  ROWS_MAX  = CNT_W'(ROWS);
	localparam logic [CNT_W-1:0]  COLS_MAX  = CNT_W'(COLS);
	localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

	state_t                    state_q;
	logic [STEP_W-1:0]         step_q;
	logic [ROW_W-1:0]          pos_q;
	logic [ROW_W-1:0]          row_q;
	logic                      gap_seen_q;
	logic                      last_q;
	logic                      cplx_q;
	logic [CNT_W-1:0]          nout_q;
	logic signed [SAMP_W-1:0]  samp_re_q;
	logic signed [SAMP_W-1:0]  samp_im_q;
	logic                      complex_mode_q;
	logic [CFG_DATA_W-1:0]     input_count_q;
	logic [CFG_DATA_W-1:0]     column_count_q;
	logic                      out_valid_q;
	logic [STEP_W-1:0]         out_channel_q;
	logic signed [ACC_W-1:0]   out_real_q;
	logic signed [ACC_W-1:0]   out_imag_q;
	logic                      frame_last_q;

	logic                      in_fire;
	logic                      load_fire;
	logic                      samp_fire;
	logic [CNT_W-1:0]          rows_use;
	logic [CNT_W-1:0]          cols_use;
	logic [CNT_W-1:0]          nout_now;
	logic                      frame_end_now;
	logic                      emit_fire;
	logic                      emit_live;
	mac_req_t                  req;
	logic [BANK_AW-1:0]        rd_addr;
	logic signed [COEF_W-1:0]  coef_even;
	logic signed [COEF_W-1:0]  coef_odd;
	contrib_t                  contrib;
	contrib_t                  tail_add;
	logic                      mac_busy;
	logic                      ring_shift;
	acc_t                      ring_feed;
	acc_t                      acc [OUTS];

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign load_fire = in_fire && (cmd == CMD_LOAD);
	assign samp_fire = in_fire && (cmd == CMD_SAMPLE);

	// Register values outside the legal range are clamped, zero counting as one.
	always_comb begin
		if (input_count_q == '0) begin
			rows_use = CNT_ONE;
		end else if (CNT_W'(input_count_q) > ROWS_MAX) begin
			rows_use = ROWS_MAX;
		end else begin
			rows_use = CNT_W'(input_count_q);
		end
		if (column_count_q == '0) begin
			cols_use = CNT_ONE;
		end else if (CNT_W'(column_count_q) > COLS_MAX) begin
			cols_use = COLS_MAX;
		end else begin
			cols_use = CNT_W'(column_count_q);
		end
		nout_now = complex_mode_q ? (cols_use >> 1) : cols_use;
	end

	assign frame_end_now = (CNT_W'(pos_q) + CNT_ONE) >= rows_use;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complex_mode_q <= 1'b0;
			input_count_q  <= CFG_DATA_W'(1);
			column_count_q <= CFG_DATA_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COMPLEX_MODE: complex_mode_q <= cfg_data[0];
				CFG_INPUT_COUNT:  input_count_q  <= cfg_data;
				CFG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mcm_coef_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (load_fire),
		.wr_row  (coef_row),
		.wr_col  (coef_column),
		.wr_data (coef_value),
		.rd_en   (req.valid),
		.rd_addr (rd_addr),
		.rd_even (coef_even),
		.rd_odd  (coef_odd)
	);

	// Ring position k fetches column k in real mode and the pair 2k, 2k+1 in complex mode.
	always_comb begin
		req.valid = (state_q == ST_MAC);
		req.live  = CNT_W'(step_q) < nout_q;
		req.cplx  = cplx_q;
		req.step  = step_q;
		if (cplx_q) begin
			rd_addr = {row_q, step_q[STEP_W-2:0]};
		end else begin
			rd_addr = {row_q, step_q[STEP_W-1:1]};
		end
	end

	mcm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.sample_re (samp_re_q),
		.sample_im (samp_im_q),
		.coef_even (coef_even),
		.coef_odd  (coef_odd),
		.contrib   (contrib),
		.busy      (mac_busy)
	);

	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign emit_live = CNT_W'(step_q) < nout_q;

	// Products enter at the tail while the head wraps around; while results go out
	// the head leaves the ring and zeros come in, which clears it for the next frame.
	assign ring_shift = contrib.valid || emit_fire;
	assign ring_feed  = (state_q == ST_EMIT) ? '0 : acc[0];

	always_comb begin
		tail_add      = contrib;
		tail_add.live = contrib.valid && contrib.live;
	end

	for (genvar i = 0; i < OUTS; i++) begin : g_ring
		if (i == OUTS - 1) begin : g_tail
			mcm_acc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ring_shift),
				.prev   (ring_feed),
				.add    (tail_add),
				.acc    (acc[i])
			);
		end else begin : g_body
			mcm_acc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (ring_shift),
				.prev   (acc[i+1]),
				.add    ('0),
				.acc    (acc[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			pos_q      <= '0;
			gap_seen_q <= 1'b0;
			last_q     <= 1'b0;
			cplx_q     <= 1'b0;
			nout_q     <= '0;
			row_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (samp_fire) begin
						row_q      <= pos_q;
						pos_q      <= frame_end_now ? '0 : pos_q + ROW_W'(1);
						last_q     <= frame_end_now;
						gap_seen_q <= gap_seen_q | gap;
						cplx_q     <= complex_mode_q;
						nout_q     <= nout_now;
						step_q     <= '0;
						state_q    <= ST_MAC;
					end
				end
				ST_MAC: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_busy) begin
						step_q  <= '0;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						step_q <= step_q + STEP_W'(1);
						if (step_q == STEP_LAST) begin
							gap_seen_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (samp_fire) begin
			samp_re_q <= sample_real;
			samp_im_q <= sample_imag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= emit_live;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire && emit_live) begin
			out_channel_q <= step_q;
			out_real_q    <= gap_seen_q ? '0 : acc[0].re;
			out_imag_q    <= (gap_seen_q || !cplx_q) ? '0 : acc[0].im;
			frame_last_q  <= (CNT_W'(step_q) + CNT_ONE) == nout_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign out_real    = out_real_q;
	assign out_imag    = out_imag_q;
	assign frame_last  = frame_last_q;

endmodule

FILE: design/mcm_checker.sv
// Port-level assertions on the result stream of the channel mixer, bound to the top level.
module mcm_checker import mcm_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [STEP_W-1:0]       out_channel,
	input logic signed [ACC_W-1:0] out_real,
	input logic signed [ACC_W-1:0] out_imag,
	input logic                    frame_last
);

	localparam logic [STEP_W-1:0] CHAN_LAST = STEP_W'(OUTS - 1);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_channel) && $stable(out_real)
			&& $stable(out_imag) && $stable(frame_last))
		else $error("stalled result request changed");

	a_top_channel_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_channel == CHAN_LAST) |-> frame_last)
		else $error("highest output channel not marked as frame end");

	a_new_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && frame_last |=> !out_valid || (out_channel == '0))
		else $error("frame did not restart at output channel zero");

	a_channel_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !frame_last
			|=> !out_valid || (out_channel == STEP_W'($past(out_channel) + STEP_W'(1))))
		else $error("output channels out of order within a frame");

endmodule

bind matrix_channel_mixer mcm_checker u_mcm_checker (.*);

FILE: tb/tb_matrix_channel_mixer.sv
// Self-checking testbench for the channel mixing matrix: directed table plus random frames.
`timescale 1ns / 1ps

module tb_matrix_channel_mixer import mcm_pkg::*;;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 48;
	localparam int ITEM_TARGET   = 300;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic                     op;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         col;
		logic signed [COEF_W-1:0] cv;
		logic signed [SAMP_W-1:0] sr;
		logic signed [SAMP_W-1:0] si;
		logic                     g;
	} mix_in_t;

	typedef struct packed {
		logic [STEP_W-1:0]       chan;
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
		logic                    last;
	} mix_out_t;

	// A typed row carries its expected real sum; its imaginary part is expected to be zero.
	typedef struct packed {
		logic                    is_cfg;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
		mix_in_t                 item;
		logic                    typed;
		logic signed [ACC_W-1:0] t_re;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic cmd;
	logic [ROW_W-1:0] coef_row;
	logic [COL_W-1:0] coef_column;
	logic signed [COEF_W-1:0] coef_value;
	logic signed [SAMP_W-1:0] sample_real;
	logic signed [SAMP_W-1:0] sample_imag;
	logic gap;
	logic out_valid;
	logic out_stall;
	logic [STEP_W-1:0] out_channel;
	logic signed [ACC_W-1:0] out_real;
	logic signed [ACC_W-1:0] out_imag;
	logic frame_last;

	// Shadow state of the mixer.
	logic signed [COEF_W-1:0] coef_bank [ROWS][COLS];
	longint acc_re [OUTS];
	longint acc_im [OUTS];
	int frame_pos;
	bit frame_gap;
	logic mode_cplx;
	logic [CFG_DATA_W-1:0] n_inputs;
	logic [CFG_DATA_W-1:0] n_cols;

	mix_out_t mixed_due[$];
	mix_out_t got_mix;
	mix_out_t want_mix;
	plan_row_t plan[$];

	int err_count;
	int cycle_count;
	int sent_items;
	int send_idle_pct;
	int stall_pct;

	matrix_channel_mixer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.coef_row(coef_row),
		.coef_column(coef_column),
		.coef_value(coef_value),
		.sample_real(sample_real),
		.sample_imag(sample_imag),
		.gap(gap),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_channel(out_channel),
		.out_real(out_real),
		.out_imag(out_imag),
		.frame_last(frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int rows_used();
		int n;
		n = int'(n_inputs);
		if (n > ROWS) n = ROWS;
		if (n < 1) n = 1;
		return n;
	endfunction

	function automatic int cols_used();
		int n;
		n = int'(n_cols);
		if (n > COLS) n = COLS;
		if (n < 1) n = 1;
		return n;
	endfunction

	function automatic int outs_used();
		int n;
		n = cols_used();
		if (mode_cplx) n = n / 2;
		if (n > OUTS) n = OUTS;
		return n;
	endfunction

	// Applies one accepted request to the shadow state and queues the results it closes.
	function automatic void mix_frame_step(input mix_in_t it, input bit typed,
			input logic signed [ACC_W-1:0] t_re);
		int nout;
		int k;
		longint sr;
		longint si;
		longint cr;
		longint ci;
		mix_out_t r;
		if (it.op == CMD_LOAD) begin
			coef_bank[it.row][it.col] = it.cv;
			return;
		end
		sr = longint'($signed(it.sr));
		si = longint'($signed(it.si));
		if (it.g) frame_gap = 1'b1;
		nout = outs_used();
		for (k = 0; k < nout; k++) begin
			if (mode_cplx) begin
				cr = longint'(coef_bank[frame_pos][2 * k]);
				ci = longint'(coef_bank[frame_pos][2 * k + 1]);
				acc_re[k] += sr * cr - si * ci;
				acc_im[k] += sr * ci + si * cr;
			end else begin
				acc_re[k] += sr * longint'(coef_bank[frame_pos][k]);
			end
		end
		if (frame_pos + 1 < rows_used()) begin
			frame_pos = frame_pos + 1;
			return;
		end
		for (k = 0; k < nout; k++) begin
			r.chan = k[STEP_W-1:0];
			r.re = frame_gap ? '0 : (typed ? t_re : acc_re[k][ACC_W-1:0]);
			r.im = (frame_gap || typed || !mode_cplx) ? '0 : acc_im[k][ACC_W-1:0];
			r.last = (k + 1 == nout);
			mixed_due.push_back(r);
		end
		for (k = 0; k < OUTS; k++) begin
			acc_re[k] = 0;
			acc_im[k] = 0;
		end
		frame_pos = 0;
		frame_gap = 1'b0;
	endfunction

	function automatic plan_row_t ld(input int r, input int c, input int v);
		plan_row_t p;
		p = '0;
		p.item.op = CMD_LOAD;
		p.item.row = r[ROW_W-1:0];
		p.item.col = c[COL_W-1:0];
		p.item.cv = v[COEF_W-1:0];
		return p;
	endfunction

	function automatic plan_row_t smp(input int re, input int im, input bit g, input bit typed,
			input logic signed [ACC_W-1:0] t_re);
		plan_row_t p;
		p = '0;
		p.item.op = CMD_SAMPLE;
		p.item.sr = re[SAMP_W-1:0];
		p.item.si = im[SAMP_W-1:0];
		p.item.g = g;
		p.typed = typed;
		p.t_re = t_re;
		return p;
	endfunction

	function automatic plan_row_t wr(input logic [CFG_IDX_W-1:0] idx, input int data);
		plan_row_t p;
		p = '0;
		p.is_cfg = 1'b1;
		p.idx = idx;
		p.data = data[CFG_DATA_W-1:0];
		return p;
	endfunction

	function automatic logic signed [SAMP_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return SAMP_W'($urandom());
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return 18'sh20000;
			1: return 18'sh1ffff;
			default: return COEF_W'($urandom());
		endcase
	endfunction

	// In the first third the receiver stalls more often than the sender idles; then reversed; then neither.
	task automatic push_request(input mix_in_t it, input bit typed,
			input logic signed [ACC_W-1:0] t_re);
		int gap_len;
		if (sent_items < ITEM_TARGET / 3) begin
			send_idle_pct = 26;
			stall_pct = 68;
		end else if (sent_items < 2 * ITEM_TARGET / 3) begin
			send_idle_pct = 68;
			stall_pct = 26;
		end else begin
			send_idle_pct = 0;
			stall_pct = 0;
		end
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			gap_len = $urandom_range(1, 3);
			repeat (gap_len) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.op;
		coef_row <= it.row;
		coef_column <= it.col;
		coef_value <= it.cv;
		sample_real <= it.sr;
		sample_imag <= it.si;
		gap <= it.g;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		mix_frame_step(it, typed, t_re);
		sent_items++;
	endtask

	// Holds off new requests until every expected result is out and the pipeline is quiet.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (mixed_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_COMPLEX_MODE: mode_cplx = data[0];
			CFG_INPUT_COUNT:  n_inputs = data;
			CFG_COLUMN_COUNT: n_cols = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_load(input int rows, input int cols);
		mix_in_t it;
		it = '0;
		it.op = CMD_LOAD;
		it.row = ROW_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, ROWS - 1) :
			$urandom_range(0, rows - 1));
		it.col = COL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, COLS - 1) :
			$urandom_range(0, cols - 1));
		it.cv = pick_coef();
		it.sr = SAMP_W'($urandom());
		it.si = SAMP_W'($urandom());
		it.g = ($urandom_range(0, 1) == 1);
		push_request(it, 1'b0, '0);
	endtask

	function automatic void check_field(input string name, input logic signed [ACC_W-1:0] want,
			input logic signed [ACC_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			err_count++;
		end
	endfunction

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_mix.chan = out_channel;
			got_mix.re = out_real;
			got_mix.im = out_imag;
			got_mix.last = frame_last;
			if (mixed_due.size() == 0) begin
				$display("%0t: unexpected result channel %0d real %0d imag %0d last %0d",
					$time, got_mix.chan, got_mix.re, got_mix.im, got_mix.last);
				err_count++;
			end else begin
				want_mix = mixed_due.pop_front();
				check_field("out_channel", ACC_W'(want_mix.chan), ACC_W'(got_mix.chan));
				check_field("out_real", want_mix.re, got_mix.re);
				check_field("out_imag", want_mix.im, got_mix.im);
				check_field("frame_last", ACC_W'(want_mix.last), ACC_W'(got_mix.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, mixed_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int rows;
		int cols;
		int nsamp;
		int pick;
		mix_in_t it;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		coef_row = '0;
		coef_column = '0;
		coef_value = '0;
		sample_real = '0;
		sample_imag = '0;
		gap = 1'b0;
		out_stall = 1'b0;
		err_count = 0;
		cycle_count = 0;
		sent_items = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		foreach (coef_bank[r, c]) coef_bank[r][c] = '0;
		foreach (acc_re[k]) begin
			acc_re[k] = 0;
			acc_im[k] = 0;
		end
		frame_pos = 0;
		frame_gap = 1'b0;
		mode_cplx = 1'b0;
		n_inputs = 5'd1;
		n_cols = 5'd1;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: store cleared at reset, coefficient and sample extremes, gap frames,
		// complex mode with one column, out-of-range counts, a load and a count change
		// in the middle of a frame.
		plan.push_back(smp(32767, -32768, 1'b0, 1'b1, '0));
		plan.push_back(ld(0, 0, 131071));
		plan.push_back(smp(-32768, 32767, 1'b0, 1'b1, -40'sd4294934528));
		plan.push_back(ld(0, 0, -131072));
		plan.push_back(smp(-32768, 0, 1'b0, 1'b1, 40'sd4294967296));
		plan.push_back(smp(32767, 0, 1'b1, 1'b1, '0));
		plan.push_back(wr(CFG_COMPLEX_MODE, 1));
		plan.push_back(smp(-32768, 32767, 1'b0, 1'b1, '0));
		plan.push_back(wr(CFG_COLUMN_COUNT, 31));
		plan.push_back(wr(CFG_INPUT_COUNT, 0));
		plan.push_back(ld(0, 1, -131072));
		plan.push_back(ld(0, 15, 131071));
		plan.push_back(smp(32767, -32768, 1'b1, 1'b1, '0));
		plan.push_back(smp(-32768, -32768, 1'b0, 1'b0, '0));
		plan.push_back(wr(CFG_UNUSED, 31));
		plan.push_back(wr(CFG_COMPLEX_MODE, 2));
		plan.push_back(wr(CFG_COLUMN_COUNT, 16));
		plan.push_back(wr(CFG_INPUT_COUNT, 3));
		plan.push_back(smp(100, -7, 1'b0, 1'b0, '0));
		plan.push_back(ld(1, 3, -5000));
		plan.push_back(smp(-200, 5, 1'b0, 1'b0, '0));
		plan.push_back(wr(CFG_INPUT_COUNT, 2));
		plan.push_back(smp(3000, 0, 1'b0, 1'b0, '0));
		plan.push_back(ld(15, 15, -1));
		plan.push_back(smp(1, 1, 1'b0, 1'b1, '0));
		plan.push_back(smp(-1, -1, 1'b1, 1'b1, '0));
		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].idx, plan[i].data);
			else
				push_request(plan[i].item, plan[i].typed, plan[i].t_re);
		end

		// Random part: each setting gets a few loads, then mostly whole frames.
		while (sent_items < ITEM_TARGET) begin
			write_reg(CFG_COMPLEX_MODE, CFG_DATA_W'($urandom_range(0, 31)));
			pick = $urandom_range(0, 9);
			write_reg(CFG_INPUT_COUNT, CFG_DATA_W'((pick == 0) ? 0 : (pick == 1) ? 31 :
				(pick == 2) ? 16 : $urandom_range(1, 4)));
			write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'($urandom_range(0, 31)));
			rows = rows_used();
			cols = cols_used();
			repeat ($urandom_range(2, 6)) random_load(rows, cols);
			nsamp = rows * $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0) nsamp += $urandom_range(1, rows);
			repeat (nsamp) begin
				if ($urandom_range(0, 5) == 0) random_load(rows, cols);
				it = '0;
				it.op = CMD_SAMPLE;
				it.row = ROW_W'($urandom());
				it.col = COL_W'($urandom());
				it.cv = COEF_W'($urandom());
				it.sr = pick_sample();
				it.si = pick_sample();
				it.g = ($urandom_range(0, 11) == 0);
				push_request(it, 1'b0, '0);
			end
		end

		settle();
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
design/mcm_pkg.sv
design/mcm_coef_store.sv
design/mcm_mac.sv
design/mcm_acc_cell.sv
design/matrix_channel_mixer.sv
design/mcm_checker.sv
tb/tb_matrix_channel_mixer.sv
